### hdl/cdq_pkg.sv
// Shared constants, request codes and interface types for the circular deque.
`timescale 1ns / 1ps
`default_nettype none

package cdq_pkg;

  localparam int DEPTH      = 1024;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = IDX_W + 1;
  localparam int CAP_W      = 11;
  localparam int APB_AW     = 3;
  localparam int APB_DW     = 32;

  typedef logic [2:0] kind_t;

  localparam kind_t KIND_INS_FRONT  = 3'd0;
  localparam kind_t KIND_INS_BACK   = 3'd1;
  localparam kind_t KIND_REM_FRONT  = 3'd2;
  localparam kind_t KIND_REM_BACK   = 3'd3;
  localparam kind_t KIND_PEEK_FRONT = 3'd4;
  localparam kind_t KIND_PEEK_BACK  = 3'd5;

  // Register index, taken from the word address of the configuration port.
  localparam logic REG_CAPACITY = 1'b0;

  localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(DEPTH);

  typedef struct packed {
    logic                  we;
    logic [IDX_W-1:0]      waddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic                  re;
    logic [IDX_W-1:0]      raddr;
  } mem_req_t;

  typedef struct packed {
    logic ok;
    logic peek;
    logic is_empty;
    logic is_full;
  } rsp_meta_t;

endpackage

`default_nettype wire

### hdl/cdq_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module cdq_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### hdl/cdq_ctrl.sv
// Head, tail, count and capacity registers; turns each request into a slot access.
`timescale 1ns / 1ps
`default_nettype none

module cdq_ctrl (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           accept,
  input  wire cdq_pkg::kind_t                 kind,
  input  wire logic [cdq_pkg::DATA_WIDTH-1:0] value,
  input  wire logic                           cfg_we,
  input  wire logic [cdq_pkg::CAP_W-1:0]      cfg_capacity,
  output logic      [cdq_pkg::CAP_W-1:0]      capacity,
  output cdq_pkg::mem_req_t                   mem_req,
  output cdq_pkg::rsp_meta_t                  meta
);

  logic [cdq_pkg::IDX_W-1:0] head, head_next;
  logic [cdq_pkg::IDX_W-1:0] tail, tail_next;
  logic [cdq_pkg::CNT_W-1:0] count, count_next;
  logic [cdq_pkg::CNT_W-1:0] cap_eff, cap_eff_next;

  logic                      empty, full;
  logic [cdq_pkg::IDX_W-1:0] head_up, head_down, tail_up, tail_down, cap_last;

  assign empty    = (count == '0);
  assign full     = (count >= cap_eff);
  assign cap_last = cdq_pkg::IDX_W'(cap_eff - cdq_pkg::CNT_W'(1));

  // Ring steps wrap at the effective capacity, not at the memory depth.
  assign head_up   = ((cdq_pkg::CNT_W'(head) + cdq_pkg::CNT_W'(1)) >= cap_eff) ?
                     '0 : head + cdq_pkg::IDX_W'(1);
  assign tail_up   = ((cdq_pkg::CNT_W'(tail) + cdq_pkg::CNT_W'(1)) >= cap_eff) ?
                     '0 : tail + cdq_pkg::IDX_W'(1);
  assign head_down = (head == '0) ? cap_last : head - cdq_pkg::IDX_W'(1);
  assign tail_down = (tail == '0) ? cap_last : tail - cdq_pkg::IDX_W'(1);

  always_comb begin
    head_next     = head;
    tail_next     = tail;
    count_next    = count;
    mem_req.we    = 1'b0;
    mem_req.waddr = '0;
    mem_req.wdata = value;
    mem_req.re    = 1'b0;
    mem_req.raddr = head;
    meta.ok       = 1'b0;
    meta.peek     = 1'b0;

    case (kind) inside
      cdq_pkg::KIND_INS_FRONT, cdq_pkg::KIND_INS_BACK: begin
        if (!full) begin
          if (empty) begin
            head_next     = '0;
            tail_next     = '0;
            mem_req.waddr = '0;
          end else if (kind == cdq_pkg::KIND_INS_FRONT) begin
            head_next     = head_down;
            mem_req.waddr = head_down;
          end else begin
            tail_next     = tail_up;
            mem_req.waddr = tail_up;
          end
          mem_req.we = accept;
          count_next = count + cdq_pkg::CNT_W'(1);
          meta.ok    = 1'b1;
        end
      end
      cdq_pkg::KIND_REM_FRONT, cdq_pkg::KIND_REM_BACK: begin
        if (!empty) begin
          if (count == cdq_pkg::CNT_W'(1)) begin
            head_next = '0;
            tail_next = '0;
          end else if (kind == cdq_pkg::KIND_REM_FRONT) begin
            head_next = head_up;
          end else begin
            tail_next = tail_down;
          end
          count_next = count - cdq_pkg::CNT_W'(1);
          meta.ok    = 1'b1;
        end
      end
      cdq_pkg::KIND_PEEK_FRONT, cdq_pkg::KIND_PEEK_BACK: begin
        if (!empty) begin
          mem_req.re    = accept;
          mem_req.raddr = (kind == cdq_pkg::KIND_PEEK_FRONT) ? head : tail;
          meta.ok       = 1'b1;
          meta.peek     = 1'b1;
        end
      end
      default: begin
      end
    endcase

    meta.is_empty = (count_next == '0);
    meta.is_full  = (count_next >= cap_eff);
  end

  // Out-of-range capacity is clamped once, when it is written.
  always_comb begin
    if (cfg_capacity == '0) begin
      cap_eff_next = cdq_pkg::CNT_W'(1);
    end else if (cdq_pkg::CNT_W'(cfg_capacity) > cdq_pkg::CNT_W'(cdq_pkg::DEPTH)) begin
      cap_eff_next = cdq_pkg::CNT_W'(cdq_pkg::DEPTH);
    end else begin
      cap_eff_next = cdq_pkg::CNT_W'(cfg_capacity);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      tail     <= '0;
      count    <= '0;
      capacity <= cdq_pkg::CAPACITY_RESET;
      cap_eff  <= cdq_pkg::CNT_W'(cdq_pkg::DEPTH);
    end else if (cfg_we) begin
      // A capacity write empties the deque.
      head     <= '0;
      tail     <= '0;
      count    <= '0;
      capacity <= cfg_capacity;
      cap_eff  <= cap_eff_next;
    end else if (accept) begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

endmodule

`default_nettype wire

### hdl/circular_deque.sv
// Circular deque of signed words: request stage, slot memory, result register.
// A request accepted at a clock edge passes through the pending stage, then the result register.
// Throughput: one request per cycle while req_stall is low; the pointer registers
// update in the accept cycle and a peek reads the slot memory into the pending stage.
// Reset (synchronous): deque empty, both pointers 0, capacity 1024, no result pending.
// Slot contents are not cleared; only slots holding live entries are ever read.
`timescale 1ns / 1ps
`default_nettype none

module circular_deque (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              req_valid,
  output logic                                   req_stall,
  input  wire logic [2:0]                        kind,
  input  wire logic signed [31:0]                value,
  output logic                                   rsp_valid,
  input  wire logic                              rsp_stall,
  output logic                                   ok,
  output logic signed [31:0]                     data,
  output logic                                   is_empty,
  output logic                                   is_full,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [cdq_pkg::APB_AW-1:0]        paddr,
  input  wire logic [cdq_pkg::APB_DW-1:0]        pwdata,
  output logic      [cdq_pkg::APB_DW-1:0]        prdata,
  output logic                                   pready
);

  logic                               accept;
  logic                               cfg_we;
  logic [cdq_pkg::CAP_W-1:0]          capacity;
  cdq_pkg::mem_req_t                  mem_req;
  cdq_pkg::rsp_meta_t                 meta;
  cdq_pkg::rsp_meta_t                 p_meta;
  logic                               p_valid;
  logic                               p_move;
  logic [cdq_pkg::DATA_WIDTH-1:0]     rdata;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == cdq_pkg::REG_CAPACITY);
  assign prdata = (paddr[2] == cdq_pkg::REG_CAPACITY) ?
                  cdq_pkg::APB_DW'(capacity) : '0;

  // The pending stage waits for the memory read; it drains when the result register frees.
  assign p_move    = p_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = p_valid && !p_move;
  assign accept    = req_valid && !req_stall;

  cdq_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .kind         (kind),
    .value        (value),
    .cfg_we       (cfg_we),
    .cfg_capacity (pwdata[cdq_pkg::CAP_W-1:0]),
    .capacity     (capacity),
    .mem_req      (mem_req),
    .meta         (meta)
  );

  cdq_ram #(
    .DEPTH (cdq_pkg::DEPTH),
    .WIDTH (cdq_pkg::DATA_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (accept) begin
      p_valid <= 1'b1;
    end else if (p_move) begin
      p_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_meta <= meta;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (p_move) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p_move) begin
      ok       <= p_meta.ok;
      data     <= p_meta.peek ? rdata : '1;
      is_empty <= p_meta.is_empty;
      is_full  <= p_meta.is_full;
    end
  end

endmodule

`default_nettype wire

### hdl/cdq_checker.sv
// Port-level assertions for the circular deque, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module cdq_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               rsp_valid,
  input wire logic               rsp_stall,
  input wire logic               ok,
  input wire logic signed [31:0] data,
  input wire logic               is_empty,
  input wire logic               is_full
);

  // Nothing comes out in the cycle after reset.
  a_idle_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("result valid right after reset");

  // Capacity is at least one, so an empty deque can never be full.
  a_empty_not_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(is_empty && is_full))
    else $error("deque reported empty and full at once");

  // A failed request never carries a word.
  a_fail_data: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !ok) |-> (data == -32'sd1))
    else $error("failed request returned data other than all ones");

  // A stalled result item holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(ok) && $stable(data)
                                  && $stable(is_empty) && $stable(is_full)))
    else $error("stalled result item changed");

endmodule

bind circular_deque cdq_checker u_cdq_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .ok        (ok),
  .data      (data),
  .is_empty  (is_empty),
  .is_full   (is_full)
);

`default_nettype wire
